// ===== rtl/ranked_value_table_assert.svh =====
// ---------------------------------------------------------------------------
// ranked_value_table_assert.svh
// Assertion macros for the ranked value table. Empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef RANKED_VALUE_TABLE_ASSERT_SVH
`define RANKED_VALUE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// check an implication on every clock edge outside reset
`define RVT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rvt assertion failed");
// check that the consequent holds in the cycle after the antecedent
`define RVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rvt assertion failed");
`else
`define RVT_ASSERT_IMPL(lbl, ante, cons)
`define RVT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/rvt_pkg.sv =====
// ---------------------------------------------------------------------------
// rvt_pkg
// Shared types, constants and the chain ordering function.
// ---------------------------------------------------------------------------
`default_nettype none
package rvt_pkg;

    localparam int DEF_MAX_ITEMS = 1024;
    localparam int ENTRY_ID_W    = 12;
    localparam int CFG_W         = 11;

    // id that sorts after every real entry of equal value
    localparam logic [ENTRY_ID_W-1:0] FILLER_ID = '1;

    typedef struct packed {
        logic              action;
        logic [10:0]       item_id;
        logic signed [31:0] item_value;
        logic [10:0]       rank;
    } t_in_item;

    typedef struct packed {
        logic [10:0] ranked_id;
        logic        rank_error;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0]    value;
        logic [ENTRY_ID_W-1:0] id;
    } t_entry;

    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_REMOVE = 2'd1,
        CM_INSERT = 2'd2,
        CM_ROTATE = 2'd3
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        t_entry     key;
    } t_cell_ctl;

    localparam t_entry FILLER_ENTRY = '{value: 32'sh8000_0000, id: FILLER_ID};

    // true if entry a stands before entry b: greater value, then smaller id
    function automatic logic ahead(input t_entry a, input t_entry b);
        logic res;
        if (a.value != b.value) begin
            res = (a.value > b.value);
        end else begin
            res = (a.id < b.id);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rvt_cell.sv =====
// ---------------------------------------------------------------------------
// rvt_cell
// One slot of the sorted chain: holds an entry and moves it to or from
// its neighbors on remove, insert and rotate steps.
// ---------------------------------------------------------------------------
`default_nettype none
module rvt_cell
    import rvt_pkg::*;
#(
    parameter logic [ENTRY_ID_W-1:0] RESET_ID = '0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_left,
    input  wire t_entry    i_right,
    input  wire logic      i_left_ins,
    output t_entry         o_entry,
    output logic           o_ins
);

    t_entry r_entry;
    t_entry n_entry;

    // broadcast key stands before this entry
    assign o_ins = ahead(i_ctl.key, r_entry);

    // pick next entry
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.mode)
            CM_REMOVE: begin
                if (!ahead(r_entry, i_ctl.key)) n_entry = i_right;
            end
            CM_INSERT: begin
                if (i_left_ins) n_entry = i_left;
                else if (o_ins) n_entry = i_ctl.key;
            end
            CM_ROTATE: n_entry = i_right;
            default:   n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.value <= '0;
            r_entry.id    <= RESET_ID;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

// ===== rtl/rvt_chain.sv =====
// ---------------------------------------------------------------------------
// rvt_chain
// Row of cells holding all entries in ranked order; the head cell is
// visible to the controller for rank scans.
// ---------------------------------------------------------------------------
`default_nettype none
module rvt_chain
    import rvt_pkg::*;
#(
    parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    output t_entry         o_head
);

    t_entry entries [MAX_ITEMS];
    logic   ins     [MAX_ITEMS];

    genvar k;
    generate
        for (k = 0; k < MAX_ITEMS; k++) begin : g_cell
            t_entry left_e;
            t_entry right_e;
            logic   left_ins;

            // wire neighbors; ends take filler, or wrap when rotating
            if (k == 0) begin : g_first
                assign left_e   = FILLER_ENTRY;
                assign left_ins = 1'b0;
            end else begin : g_mid
                assign left_e   = entries[k-1];
                assign left_ins = ins[k-1];
            end
            if (k == MAX_ITEMS - 1) begin : g_last
                assign right_e = (i_ctl.mode == CM_ROTATE) ? entries[0] : FILLER_ENTRY;
            end else begin : g_inner
                assign right_e = entries[k+1];
            end

            rvt_cell #(
                .RESET_ID(ENTRY_ID_W'(k + 1))
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (i_ctl),
                .i_left    (left_e),
                .i_right   (right_e),
                .i_left_ins(left_ins),
                .o_entry   (entries[k]),
                .o_ins     (ins[k])
            );
        end
    endgenerate

    assign o_head = entries[0];

endmodule
`default_nettype wire

// ===== rtl/ranked_value_table.sv =====
// Ranked value table: a set transaction steps through accept, value read, remove and insert.
// A query rotates the whole cell chain once, one entry past the head cell per cycle; the result
// is registered after the scan, and the next transaction is taken once it enters the output register.
// A query with a bad rank skips the scan and goes straight to the result state. One at a time.
// Synchronous active-low reset; afterwards a clearing pass zeroes the value
// memory while no input transaction is taken.
// ---------------------------------------------------------------------------
// ranked_value_table
// Top level: controller, per-item value memory and the sorted cell chain.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ranked_value_table_assert.svh"
module ranked_value_table
    import rvt_pkg::*;
#(
    parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int AddrW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_ITEMS - 1);
    localparam logic [ENTRY_ID_W-1:0] MaxId = ENTRY_ID_W'(MAX_ITEMS);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_REMOVE = 7'b0001000,
        ST_INSERT = 7'b0010000,
        ST_SCAN   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state                r_state;
    logic [CFG_W-1:0]      r_items;
    logic [AddrW-1:0]      r_cnt_addr;
    logic [ENTRY_ID_W-1:0] r_n;
    logic [ENTRY_ID_W-1:0] r_count;
    logic [10:0]           r_rank;
    logic                  r_found;
    t_entry                r_key;
    logic [AddrW-1:0]      r_addr;
    logic signed [31:0]    r_old;
    t_out_item             r_res;
    t_out_item             r_out;
    logic                  r_out_valid;
    logic signed [31:0]    r_mem [MAX_ITEMS];

    t_cell_ctl             chain_ctl;
    t_entry                head;
    logic                  accept;
    logic                  out_free;
    logic [ENTRY_ID_W-1:0] in_id;
    logic [ENTRY_ID_W-1:0] n_items;
    logic                  rank_bad;
    logic [10:0]           id_m1;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_id    = ENTRY_ID_W'(i_in.item_id);
    assign id_m1    = i_in.item_id - 11'd1;
    assign n_items  = ({1'b0, r_items} > MaxId) ? MaxId : ENTRY_ID_W'(r_items);
    assign rank_bad = (i_in.rank == 11'd0) || (ENTRY_ID_W'(i_in.rank) > n_items);

    // drive chain step
    always_comb begin
        chain_ctl.mode = CM_HOLD;
        chain_ctl.key  = r_key;
        case (r_state)
            ST_REMOVE: begin
                chain_ctl.mode      = CM_REMOVE;
                chain_ctl.key.value = r_old;
            end
            ST_INSERT: chain_ctl.mode = CM_INSERT;
            ST_SCAN:   chain_ctl.mode = CM_ROTATE;
            default:   chain_ctl.mode = CM_HOLD;
        endcase
    end

    rvt_chain #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (chain_ctl),
        .o_head (head)
    );

    // value memory: clear after reset, write on insert, read old value on set
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_mem[r_cnt_addr] <= '0;
        end else if (r_state == ST_INSERT) begin
            r_mem[r_addr] <= r_key.value;
        end
        if (r_state == ST_READ) begin
            r_old <= r_mem[r_addr];
        end
    end

    // hold item count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_items <= i_cfg_data;
        end
    end

    // sequence each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cnt_addr <= '0;
            r_found    <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_cnt_addr <= r_cnt_addr + 1'b1;
                    if (r_cnt_addr == LastAddr) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_key.value <= i_in.item_value;
                        r_key.id    <= in_id;
                        r_addr      <= id_m1[AddrW-1:0];
                        r_rank      <= i_in.rank;
                        r_n         <= n_items;
                        r_count     <= '0;
                        r_found     <= 1'b0;
                        r_cnt_addr  <= '0;
                        if (i_in.action) begin
                            r_res.ranked_id  <= '0;
                            r_res.rank_error <= 1'b1;
                            r_state          <= rank_bad ? ST_DONE : ST_SCAN;
                        end else if (in_id != '0 && in_id <= MaxId) begin
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ:   r_state <= ST_REMOVE;
                ST_REMOVE: r_state <= ST_INSERT;
                ST_INSERT: r_state <= ST_IDLE;
                ST_SCAN: begin
                    // count eligible ids as they pass the head
                    if (head.id <= r_n && !r_found) begin
                        r_count <= r_count + 1'b1;
                        if (r_count + 1'b1 == ENTRY_ID_W'(r_rank)) begin
                            r_found          <= 1'b1;
                            r_res.ranked_id  <= head.id[10:0];
                            r_res.rank_error <= 1'b0;
                        end
                    end
                    r_cnt_addr <= r_cnt_addr + 1'b1;
                    if (r_cnt_addr == LastAddr) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
            r_out       <= r_res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `RVT_ASSERT_IMPL(a_err_zero_id, o_out_valid && o_out.rank_error, o_out.ranked_id == 11'd0)
    `RVT_ASSERT_IMPL(a_found_nonzero, r_state == ST_DONE && !r_res.rank_error, r_res.ranked_id != 11'd0)
    `RVT_ASSERT_NEXT(a_insert_done, r_state == ST_INSERT, r_state == ST_IDLE)
    `RVT_ASSERT_IMPL(a_head_real, r_state == ST_IDLE, head.id != FILLER_ID)

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives set and query transactions into the ranked value table, predicts the
// id found at each queried rank from a sorted copy of the table, and compares
// every result field by field under random idle and stall on both channels.
// ---------------------------------------------------------------------------
module testbench;
    import rvt_pkg::*;

    localparam int TABLE_SIZE = DEF_MAX_ITEMS;
    localparam int STALL_LIMIT = 30000;
    localparam logic ACT_SET = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out;
    logic i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    // shared state of the predictor, stimulus and checker
    logic signed [31:0] item_val [1:TABLE_SIZE];
    int unsigned chain_ids [$];
    int unsigned active_count = 1;
    t_out_item rank_answers [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int idle_cycles = 0;

    ranked_value_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // greater value first, then smaller id
    function automatic bit ranks_ahead(logic signed [31:0] va, int unsigned ia,
                                       logic signed [31:0] vb, int unsigned ib);
        if (va != vb) return va > vb;
        return ia < ib;
    endfunction

    // move one item to its new place in the sorted chain
    function automatic void place_item(int unsigned id, logic signed [31:0] val);
        int p;
        for (p = 0; p < chain_ids.size(); p++) begin
            if (chain_ids[p] == id) break;
        end
        chain_ids.delete(p);
        item_val[id] = val;
        for (p = 0; p < chain_ids.size(); p++) begin
            if (ranks_ahead(val, id, item_val[chain_ids[p]], chain_ids[p])) break;
        end
        chain_ids.insert(p, id);
    endfunction

    // id at a rank among items 1..N
    function automatic t_out_item ranked_answer(int unsigned rank);
        t_out_item res;
        int unsigned n;
        int unsigned hits;
        res = '{ranked_id: '0, rank_error: 1'b1};
        n = (active_count > TABLE_SIZE) ? TABLE_SIZE : active_count;
        if (rank == 0 || rank > n) return res;
        hits = 0;
        foreach (chain_ids[k]) begin
            if (chain_ids[k] <= n) begin
                hits++;
                if (hits == rank) begin
                    res.ranked_id = 11'(chain_ids[k]);
                    res.rank_error = 1'b0;
                    return res;
                end
            end
        end
        return res;
    endfunction

    // drive one transaction and predict once it is taken
    task automatic send_item(t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            i_in = t_in_item'({$urandom, $urandom});
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in = it;
        do @(posedge i_clk); while (o_in_stall);
        if (it.action == ACT_SET) begin
            if (it.item_id >= 1 && it.item_id <= TABLE_SIZE)
                place_item(it.item_id, it.item_value);
        end else begin
            rank_answers.push_back(ranked_answer(it.rank));
        end
    endtask

    task automatic set_value(int unsigned id, logic signed [31:0] val);
        send_item('{action: ACT_SET, item_id: id[10:0], item_value: val,
                    rank: 11'($urandom)});
    endtask

    task automatic ask_rank(int unsigned rank);
        send_item('{action: ACT_QUERY, item_id: 11'($urandom), item_value: $urandom,
                    rank: rank[10:0]});
    endtask

    // hold the input until every answer is back and the last set has settled
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (rank_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_count(int unsigned n);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = n[CFG_W-1:0];
        active_count = n[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'sh7FFF_FFFF - $urandom_range(2);
            2: return 32'sh8000_0000 + $urandom_range(2);
            default: return $signed($urandom_range(6)) - 3;
        endcase
    endfunction

    task automatic test_directed();
        set_value(1, 32'sh7FFF_FFFF);
        ask_rank(1);
        ask_rank(0);
        ask_rank(2);
        ask_rank(2047);
        // bad ids are dropped
        set_value(0, 32'sh8000_0000);
        set_value(2047, 32'sh8000_0000);
        ask_rank(1);
        write_count(0);
        ask_rank(1);
        write_count(4);
        set_value(2, 32'sh8000_0000);
        set_value(3, 32'sh8000_0000);
        set_value(4, 0);
        for (int r = 1; r <= 5; r++) ask_rank(r);
        // item above N joins once N covers it
        set_value(6, 32'sh7FFF_FFFF);
        set_value(5, -1);
        ask_rank(1);
        write_count(6);
        ask_rank(1);
        ask_rank(6);
    endtask

    task automatic test_full_table();
        write_count(2047);
        for (int id = 1; id <= TABLE_SIZE; id++) set_value(id, pick_value());
        ask_rank(1);
        ask_rank(TABLE_SIZE);
        ask_rank(TABLE_SIZE + 1);
        ask_rank($urandom_range(2, TABLE_SIZE - 1));
        write_count(TABLE_SIZE);
        ask_rank(TABLE_SIZE);
        ask_rank(TABLE_SIZE + 1);
    endtask

    task automatic test_random_mix(int count, int sidle, int rstall);
        int unsigned n;
        int sent;
        sent = 0;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        while (sent < count) begin
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 32);
            write_count(n);
            for (int id = 1; id <= n; id++) set_value(id, pick_value());
            sent += n;
            for (int k = 0; k < 60; k++) begin
                case ($urandom_range(9))
                    0: set_value(($urandom_range(1) != 0) ? 0 : $urandom_range(1025, 2047),
                                 $urandom);
                    1, 2, 3: ask_rank($urandom_range(0, n + 2));
                    4: ask_rank($urandom_range(2047));
                    default: set_value($urandom_range(1, n + 4), pick_value());
                endcase
                sent++;
            end
        end
    endtask

    // receiver stall, random per mode
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // compare each answer with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rank_answers.size() == 0) begin
                $display("%0t: unexpected result id=%0d err=%0d", $time,
                         o_out.ranked_id, o_out.rank_error);
                fail_count++;
            end else begin
                want = rank_answers.pop_front();
                if (o_out.ranked_id !== want.ranked_id) begin
                    $display("%0t: ranked_id expected %0d actual %0d", $time,
                             want.ranked_id, o_out.ranked_id);
                    fail_count++;
                end
                if (o_out.rank_error !== want.rank_error) begin
                    $display("%0t: rank_error expected %0d actual %0d", $time,
                             want.rank_error, o_out.rank_error);
                    fail_count++;
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        for (int id = 1; id <= TABLE_SIZE; id++) begin
            item_val[id] = 0;
            chain_ids.push_back(id);
        end
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_full_table();
        test_random_mix(300, 16, 53);
        test_random_mix(300, 53, 16);
        test_random_mix(300, 0, 0);
        drain();
        if (fail_count == 0 && rank_answers.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
